// ===== design/nhrt_pkg.sv =====
// shared types, codes and helpers for the next-hop route table
`timescale 1ns / 1ps
package nhrt_pkg;

   // fixed field widths of the command and result items
   localparam int ADDR_W = 16;
   localparam int PORT_W = 4;
   localparam int DIST_W = 8;
   localparam int CMD_W  = 3;
   localparam int STS_W  = 2;
   localparam int LIM_REG_W = 3;
   localparam logic [LIM_REG_W-1:0] LIM_RESET = 3'd4;

   // command codes
   localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DETACH = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd4;

   // status codes
   localparam logic [STS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STS_W-1:0] STS_NOTFOUND = 2'd1;
   localparam logic [STS_W-1:0] STS_FULL     = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ADDR_W-1:0] dest_address;
      logic [PORT_W-1:0] port_number;
      logic [DIST_W-1:0] distance_in;
   } nhrt_req_type;

   typedef struct packed {
      logic [STS_W-1:0]  status;
      logic              found;
      logic [ADDR_W-1:0] route_address;
      logic [PORT_W-1:0] next_port;
      logic [DIST_W-1:0] route_distance;
   } nhrt_rsp_type;

   // operation applied to the slot passing the head of the ring
   typedef struct packed {
      logic upd;
      logic new_slot;
      logic det;
      logic rem;
   } nhrt_op_type;

   // true when pair a ranks after pair b in (distance, port) order
   function automatic logic ranks_after(input logic [DIST_W-1:0] da,
                                        input logic [PORT_W-1:0] pa,
                                        input logic [DIST_W-1:0] db,
                                        input logic [PORT_W-1:0] pb);
      return (da > db) || ((da == db) && (pa > pb));
   endfunction

endpackage

// ===== design/next_hop_route_table_unit.sv =====
// top level of the next-hop route table: ring of slot cells and control
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   nhrt_req_type
//   rsp       out        rsp_valid / rsp_ready   nhrt_rsp_type
//   csr       in/out     psel, penable, pready   paddr, pwdata, prdata
//
// each item turns the slot ring twice: once to scan for the address,
// a free slot and the route cursor, then once more while the head unit
// edits the chosen slot (detach edits every slot).
// reset clears all slot valid bits at once; no clearing pass.
// a new item is taken while the last result still waits in the output
// register; a stalled result holds the block only at its very end.
`timescale 1ns / 1ps
module next_hop_route_table_unit import nhrt_pkg::*; #(
   parameter int DEST_SLOTS = 64,
   parameter int NEXT_HOPS  = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  nhrt_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output nhrt_rsp_type rsp_payload,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int IW = (DEST_SLOTS > 1) ? $clog2(DEST_SLOTS) : 1;
   localparam int CW = $clog2(DEST_SLOTS + 1);
   localparam int LW = $clog2(NEXT_HOPS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_APPLY, ST_DONE} state_type;

   state_type         state_ff;
   logic [IW-1:0]     cnt_ff;
   logic [CW-1:0]     cursor_ff;
   logic [LIM_REG_W-1:0] limit_ff;
   nhrt_req_type      cmd_ff;
   logic              match_ok_ff, free_ok_ff, hita_ok_ff, hitb_ok_ff;
   logic [IW-1:0]     match_idx_ff, free_idx_ff, hita_idx_ff, hitb_idx_ff;
   logic              res_found_ff;
   logic [ADDR_W-1:0] res_addr_ff;
   logic [PORT_W-1:0] res_port_ff;
   logic [DIST_W-1:0] res_dist_ff;
   logic              rsp_valid_ff;
   nhrt_rsp_type      rsp_ff;

   logic                         c_valid [DEST_SLOTS];
   logic [ADDR_W-1:0]            c_key   [DEST_SLOTS];
   logic [NEXT_HOPS-1:0]         c_hv    [DEST_SLOTS];
   logic [NEXT_HOPS-1:0][PORT_W-1:0] c_port [DEST_SLOTS];
   logic [NEXT_HOPS-1:0][DIST_W-1:0] c_dist [DEST_SLOTS];
   logic                         n_valid [DEST_SLOTS];
   logic [ADDR_W-1:0]            n_key   [DEST_SLOTS];
   logic [NEXT_HOPS-1:0]         n_hv    [DEST_SLOTS];
   logic [NEXT_HOPS-1:0][PORT_W-1:0] n_port [DEST_SLOTS];
   logic [NEXT_HOPS-1:0][DIST_W-1:0] n_dist [DEST_SLOTS];

   logic              shift;
   logic              last;
   logic              tgt_ok;
   logic [IW-1:0]     tgt_idx;
   logic              hit;
   logic [LW-1:0]     limit;
   logic              after_cur;
   nhrt_op_type       op;
   logic              best_ok;
   logic [PORT_W-1:0] best_port;
   logic [DIST_W-1:0] best_dist;
   logic [STS_W-1:0]  status;

   assign shift     = (state_ff == ST_SCAN) || (state_ff == ST_APPLY);
   assign last      = (cnt_ff == IW'(DEST_SLOTS - 1));
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign pready      = 1'b1;

   // register file read
   assign prdata = (paddr[2] == 1'b0) ? {{(32-LIM_REG_W){1'b0}}, limit_ff} : '0;

   // effective pair limit, clamped to one .. NEXT_HOPS
   always_comb begin
      if (limit_ff == '0)
         limit = LW'(1);
      else if (32'(limit_ff) > NEXT_HOPS)
         limit = LW'(NEXT_HOPS);
      else
         limit = LW'(limit_ff);
   end

   // ring of slot cells; the head slot returns through the edit unit
   for (genvar g = 0; g < DEST_SLOTS; g++) begin : g_cell
      if (g == DEST_SLOTS - 1) begin : g_tail
         assign n_valid[g] = 1'b0;
         assign n_key[g]   = '0;
         assign n_hv[g]    = '0;
         assign n_port[g]  = '0;
         assign n_dist[g]  = '0;
      end else begin : g_link
         assign n_valid[g] = c_valid[g+1];
         assign n_key[g]   = c_key[g+1];
         assign n_hv[g]    = c_hv[g+1];
         assign n_port[g]  = c_port[g+1];
         assign n_dist[g]  = c_dist[g+1];
      end
   end

   logic                             h_valid;
   logic [ADDR_W-1:0]                h_key;
   logic [NEXT_HOPS-1:0]             h_hv;
   logic [NEXT_HOPS-1:0][PORT_W-1:0] h_port;
   logic [NEXT_HOPS-1:0][DIST_W-1:0] h_dist;

   for (genvar g = 0; g < DEST_SLOTS; g++) begin : g_slot
      if (g == DEST_SLOTS - 1) begin : g_last
         nhrt_cell #(.NH(NEXT_HOPS)) u_cell (
            .clock(clock), .reset(reset), .shift(shift),
            .valid_in(h_valid), .key_in(h_key), .hv_in(h_hv),
            .port_in(h_port), .dist_in(h_dist),
            .valid_out(c_valid[g]), .key_out(c_key[g]), .hv_out(c_hv[g]),
            .port_out(c_port[g]), .dist_out(c_dist[g])
         );
      end else begin : g_mid
         nhrt_cell #(.NH(NEXT_HOPS)) u_cell (
            .clock(clock), .reset(reset), .shift(shift),
            .valid_in(n_valid[g]), .key_in(n_key[g]), .hv_in(n_hv[g]),
            .port_in(n_port[g]), .dist_in(n_dist[g]),
            .valid_out(c_valid[g]), .key_out(c_key[g]), .hv_out(c_hv[g]),
            .port_out(c_port[g]), .dist_out(c_dist[g])
         );
      end
   end

   // slot chosen by the scan
   always_comb begin
      tgt_ok  = 1'b0;
      tgt_idx = match_idx_ff;
      unique case (cmd_ff.command)
         CMD_UPDATE: begin
            tgt_ok  = match_ok_ff || free_ok_ff;
            tgt_idx = match_ok_ff ? match_idx_ff : free_idx_ff;
         end
         CMD_REMOVE, CMD_QUERY: begin
            tgt_ok = match_ok_ff;
         end
         CMD_NEXT: begin
            tgt_ok  = hita_ok_ff || hitb_ok_ff;
            tgt_idx = hita_ok_ff ? hita_idx_ff : hitb_idx_ff;
         end
         default: begin
            tgt_ok = 1'b0;
         end
      endcase
   end

   assign hit = (state_ff == ST_APPLY) && tgt_ok && (cnt_ff == tgt_idx);

   // operation on the head slot
   always_comb begin
      op.upd      = hit && (cmd_ff.command == CMD_UPDATE);
      op.new_slot = hit && (cmd_ff.command == CMD_UPDATE) && !match_ok_ff;
      op.rem      = hit && (cmd_ff.command == CMD_REMOVE);
      op.det      = (state_ff == ST_APPLY) && (cmd_ff.command == CMD_DETACH);
   end

   nhrt_hop_unit #(.NH(NEXT_HOPS), .LW(LW)) u_hop (
      .op(op), .key(cmd_ff.dest_address), .port(cmd_ff.port_number),
      .new_dist(cmd_ff.distance_in), .limit(limit),
      .s_valid(c_valid[0]), .s_key(c_key[0]), .s_hv(c_hv[0]),
      .s_port(c_port[0]), .s_dist(c_dist[0]),
      .m_valid(h_valid), .m_key(h_key), .m_hv(h_hv),
      .m_port(h_port), .m_dist(h_dist),
      .best_ok(best_ok), .best_port(best_port), .best_dist(best_dist)
   );

   // head slot lies at or after the route cursor, or the cursor holds the end marker
   assign after_cur = (cursor_ff >= CW'(DEST_SLOTS)) || (CW'(cnt_ff) >= cursor_ff);

   // result status
   always_comb begin
      status = STS_OK;
      unique case (cmd_ff.command)
         CMD_UPDATE: if (!match_ok_ff && !free_ok_ff) status = STS_FULL;
         CMD_REMOVE: if (!match_ok_ff) status = STS_NOTFOUND;
         CMD_QUERY, CMD_NEXT: if (!res_found_ff) status = STS_NOTFOUND;
         default: status = STS_OK;
      endcase
   end

   // sequencer, scan records, results and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cursor_ff    <= CW'(DEST_SLOTS);
         limit_ff     <= LIM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite && paddr[2] == 1'b0)
            limit_ff <= pwdata[LIM_REG_W-1:0];
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff       <= req_payload;
                  match_ok_ff  <= 1'b0;
                  free_ok_ff   <= 1'b0;
                  hita_ok_ff   <= 1'b0;
                  hitb_ok_ff   <= 1'b0;
                  res_found_ff <= 1'b0;
                  res_addr_ff  <= '0;
                  res_port_ff  <= '0;
                  res_dist_ff  <= '0;
                  cnt_ff       <= '0;
                  state_ff     <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (c_valid[0] && c_key[0] == cmd_ff.dest_address && !match_ok_ff) begin
                  match_ok_ff  <= 1'b1;
                  match_idx_ff <= cnt_ff;
               end
               if (!c_valid[0] && !free_ok_ff) begin
                  free_ok_ff  <= 1'b1;
                  free_idx_ff <= cnt_ff;
               end
               if (c_valid[0] && after_cur && !hita_ok_ff) begin
                  hita_ok_ff  <= 1'b1;
                  hita_idx_ff <= cnt_ff;
               end
               if (c_valid[0] && !hitb_ok_ff) begin
                  hitb_ok_ff  <= 1'b1;
                  hitb_idx_ff <= cnt_ff;
               end
               cnt_ff <= last ? '0 : cnt_ff + 1'b1;
               if (last) state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               if (hit) begin
                  priority case (cmd_ff.command)
                     CMD_UPDATE: if (!match_ok_ff) cursor_ff <= CW'(cnt_ff);
                     CMD_QUERY: begin
                        res_found_ff <= best_ok;
                        res_port_ff  <= best_port;
                     end
                     CMD_NEXT: begin
                        res_found_ff <= 1'b1;
                        res_addr_ff  <= c_key[0];
                        res_dist_ff  <= best_ok ? best_dist : '0;
                        cursor_ff    <= CW'(cnt_ff) + 1'b1;
                     end
                     default: res_found_ff <= res_found_ff;
                  endcase
               end
               cnt_ff <= last ? '0 : cnt_ff + 1'b1;
               if (last) state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_ff.status         <= status;
                  rsp_ff.found          <= res_found_ff;
                  rsp_ff.route_address  <= res_addr_ff;
                  rsp_ff.next_port      <= res_port_ff;
                  rsp_ff.route_distance <= res_dist_ff;
                  state_ff              <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // cursor never points past the end marker
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CW'(DEST_SLOTS))
      else $error("route cursor out of range");

   // an accepted item starts the scan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SCAN && cnt_ff == '0))
      else $error("accepted item did not start a scan");

   // a finished item lands in the output register
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("finished item lost");

   // a found answer always reports status ok
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.found) |-> (rsp_ff.status == STS_OK))
      else $error("found result with error status");

   // the ring only turns while an item is at work
   a_ring_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !shift)
      else $error("ring turned while idle");

endmodule

// ===== design/nhrt_cell.sv =====
// one destination slot of the ring: key and next-hop pairs
`timescale 1ns / 1ps
module nhrt_cell import nhrt_pkg::*; #(
   parameter int NH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift,
   input  logic                      valid_in,
   input  logic [ADDR_W-1:0]         key_in,
   input  logic [NH-1:0]             hv_in,
   input  logic [NH-1:0][PORT_W-1:0] port_in,
   input  logic [NH-1:0][DIST_W-1:0] dist_in,
   output logic                      valid_out,
   output logic [ADDR_W-1:0]         key_out,
   output logic [NH-1:0]             hv_out,
   output logic [NH-1:0][PORT_W-1:0] port_out,
   output logic [NH-1:0][DIST_W-1:0] dist_out
);

   logic                      valid_ff;
   logic [ADDR_W-1:0]         key_ff;
   logic [NH-1:0]             hv_ff;
   logic [NH-1:0][PORT_W-1:0] port_ff;
   logic [NH-1:0][DIST_W-1:0] dist_ff;

   // valid bits are control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hv_ff    <= '0;
      end else if (shift) begin
         valid_ff <= valid_in;
         hv_ff    <= hv_in;
      end
   end

   // slot contents move to the neighbor while the ring turns
   always_ff @(posedge clock) begin
      if (shift) begin
         key_ff  <= key_in;
         port_ff <= port_in;
         dist_ff <= dist_in;
      end
   end

   assign valid_out = valid_ff;
   assign key_out   = key_ff;
   assign hv_out    = hv_ff;
   assign port_out  = port_ff;
   assign dist_out  = dist_ff;

endmodule

// ===== design/nhrt_hop_unit.sv =====
// edits the slot at the head of the ring and finds its best pair
`timescale 1ns / 1ps
module nhrt_hop_unit import nhrt_pkg::*; #(
   parameter int NH = 4,
   parameter int LW = 3
) (
   input  nhrt_op_type               op,
   input  logic [ADDR_W-1:0]         key,
   input  logic [PORT_W-1:0]         port,
   input  logic [DIST_W-1:0]         new_dist,
   input  logic [LW-1:0]             limit,
   input  logic                      s_valid,
   input  logic [ADDR_W-1:0]         s_key,
   input  logic [NH-1:0]             s_hv,
   input  logic [NH-1:0][PORT_W-1:0] s_port,
   input  logic [NH-1:0][DIST_W-1:0] s_dist,
   output logic                      m_valid,
   output logic [ADDR_W-1:0]         m_key,
   output logic [NH-1:0]             m_hv,
   output logic [NH-1:0][PORT_W-1:0] m_port,
   output logic [NH-1:0][DIST_W-1:0] m_dist,
   output logic                      best_ok,
   output logic [PORT_W-1:0]         best_port,
   output logic [DIST_W-1:0]         best_dist
);

   localparam int IXW = (NH > 1) ? $clog2(NH) : 1;

   logic                      b_valid;
   logic [ADDR_W-1:0]         b_key;
   logic [NH-1:0]             b_hv;
   logic [LW-1:0]             b_rank [NH];
   logic [LW-1:0]             m_rank [NH];
   logic [NH-1:0]             e_hv;
   logic [NH-1:0][PORT_W-1:0] e_port;
   logic [NH-1:0][DIST_W-1:0] e_dist;
   logic                      changed;
   logic                      hit_ok;
   logic                      free_ok;
   logic [IXW-1:0]            hit_i;
   logic [IXW-1:0]            free_i;
   logic [IXW-1:0]            worst_i;

   // a new destination starts from an empty slot
   always_comb begin
      b_valid = op.new_slot ? 1'b1 : s_valid;
      b_key   = op.new_slot ? key : s_key;
      b_hv    = op.new_slot ? '0 : s_hv;
   end

   // rank of each pair: how many valid pairs rank before it
   always_comb begin
      for (int i = 0; i < NH; i++) begin
         b_rank[i] = '0;
         for (int j = 0; j < NH; j++) begin
            if (j != i && b_hv[j] && ranks_after(s_dist[i], s_port[i], s_dist[j], s_port[j]))
               b_rank[i] = b_rank[i] + 1'b1;
         end
      end
   end

   // best pair of the incoming slot
   always_comb begin
      best_ok   = |s_hv;
      best_port = '0;
      best_dist = '0;
      for (int i = 0; i < NH; i++) begin
         if (s_hv[i] && b_rank[i] == '0) begin
            best_port = s_port[i];
            best_dist = s_dist[i];
         end
      end
   end

   // matching port, first free entry, worst pair
   always_comb begin
      hit_ok  = 1'b0;
      free_ok = 1'b0;
      hit_i   = '0;
      free_i  = '0;
      worst_i = '0;
      for (int i = 0; i < NH; i++) begin
         if (b_hv[i] && s_port[i] == port) begin
            hit_ok = 1'b1;
            hit_i  = IXW'(i);
         end
         if (!b_hv[i] && !free_ok) begin
            free_ok = 1'b1;
            free_i  = IXW'(i);
         end
         if (b_hv[i] && b_rank[i] == LW'(NH-1))
            worst_i = IXW'(i);
      end
   end

   // insert or change the pair
   always_comb begin
      e_hv    = b_hv;
      e_port  = s_port;
      e_dist  = s_dist;
      changed = 1'b0;
      if (op.upd) begin
         if (hit_ok) begin
            if (s_dist[hit_i] != new_dist) begin
               e_dist[hit_i] = new_dist;
               changed       = 1'b1;
            end
         end else if (free_ok) begin
            e_hv[free_i]   = 1'b1;
            e_port[free_i] = port;
            e_dist[free_i] = new_dist;
            changed        = 1'b1;
         end else if (!ranks_after(new_dist, port, s_dist[worst_i], s_port[worst_i])) begin
            e_port[worst_i] = port;
            e_dist[worst_i] = new_dist;
            changed         = 1'b1;
         end
      end
   end

   // ranks after the edit, for trimming to the limit
   always_comb begin
      for (int i = 0; i < NH; i++) begin
         m_rank[i] = '0;
         for (int j = 0; j < NH; j++) begin
            if (j != i && e_hv[j] && ranks_after(e_dist[i], e_port[i], e_dist[j], e_port[j]))
               m_rank[i] = m_rank[i] + 1'b1;
         end
      end
   end

   // trim, detach and remove
   always_comb begin
      m_valid = b_valid;
      m_key   = b_key;
      m_hv    = e_hv;
      m_port  = e_port;
      m_dist  = e_dist;
      if (changed) begin
         for (int i = 0; i < NH; i++) begin
            if (m_rank[i] >= limit) m_hv[i] = 1'b0;
         end
      end
      if (op.det && b_valid) begin
         for (int i = 0; i < NH; i++) begin
            if (s_port[i] == port) m_hv[i] = 1'b0;
         end
         if (m_hv == '0) m_valid = 1'b0;
      end
      if (op.rem) begin
         m_valid = 1'b0;
         m_hv    = '0;
      end
   end

endmodule

// ===== dv/next_hop_route_table_unit_tb.sv =====
// testbench for the next-hop route table: directed and random commands against a table model
`timescale 1ns / 1ps
module next_hop_route_table_unit_tb;
   import nhrt_pkg::*;

   localparam int SLOTS = 64;
   localparam int HOPS = 4;
   localparam int ITEM_CYCLES = 2 * SLOTS + 2;
   localparam int CYCLE_LIMIT = 3000000;
   localparam logic [2:0] LIMIT_REG_ADDR = 3'd0;
   localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   nhrt_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   nhrt_rsp_type rsp_payload;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // table model
   logic [LIM_REG_W-1:0] hop_limit_reg;
   logic slot_used [SLOTS];
   logic [ADDR_W-1:0] slot_addr [SLOTS];
   logic pair_used [SLOTS][HOPS];
   logic [PORT_W-1:0] pair_port [SLOTS][HOPS];
   logic [DIST_W-1:0] pair_dist [SLOTS][HOPS];
   int unsigned cursor;

   nhrt_rsp_type expected_rsps[$];
   int errors = 0;
   int rsp_count = 0;
   int cycle_count = 0;
   logic hold_off = 1'b0;
   logic [15:0] addr_pool [8];
   // gap before the next item, drawn when the last one is taken
   int next_gap = 0;
   logic req_hold = 1'b0;

   next_hop_route_table_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   function automatic int effective_limit();
      if (hop_limit_reg == 0) return 1;
      if (hop_limit_reg > HOPS) return HOPS;
      return hop_limit_reg;
   endfunction

   function automatic logic worse_than(logic [DIST_W-1:0] da, logic [PORT_W-1:0] pa,
                                       logic [DIST_W-1:0] db, logic [PORT_W-1:0] pb);
      return (da > db) || ((da == db) && (pa > pb));
   endfunction

   function automatic int slot_of(logic [ADDR_W-1:0] a);
      for (int s = 0; s < SLOTS; s++)
         if (slot_used[s] && slot_addr[s] == a) return s;
      return -1;
   endfunction

   function automatic int best_pair(int s);
      int b;
      b = -1;
      for (int h = 0; h < HOPS; h++)
         if (pair_used[s][h] && (b < 0 || worse_than(pair_dist[s][b], pair_port[s][b],
                                                     pair_dist[s][h], pair_port[s][h])))
            b = h;
      return b;
   endfunction

   function automatic int worst_pair(int s);
      int w;
      w = -1;
      for (int h = 0; h < HOPS; h++)
         if (pair_used[s][h] && (w < 0 || worse_than(pair_dist[s][h], pair_port[s][h],
                                                     pair_dist[s][w], pair_port[s][w])))
            w = h;
      return w;
   endfunction

   function automatic int pair_total(int s);
      int n;
      n = 0;
      for (int h = 0; h < HOPS; h++) if (pair_used[s][h]) n++;
      return n;
   endfunction

   function automatic void free_slot(int s);
      slot_used[s] = 1'b0;
      for (int h = 0; h < HOPS; h++) pair_used[s][h] = 1'b0;
   endfunction

   function automatic void add_pair(int s, logic [PORT_W-1:0] p, logic [DIST_W-1:0] d);
      int hit, spare, w;
      hit = -1;
      spare = -1;
      for (int h = 0; h < HOPS; h++)
         if (pair_used[s][h]) begin
            if (pair_port[s][h] == p) hit = h;
         end else if (spare < 0) spare = h;
      if (hit >= 0) begin
         if (pair_dist[s][hit] == d) return;
         pair_dist[s][hit] = d;
      end else if (spare >= 0) begin
         pair_used[s][spare] = 1'b1;
         pair_port[s][spare] = p;
         pair_dist[s][spare] = d;
      end else begin
         w = worst_pair(s);
         if (worse_than(d, p, pair_dist[s][w], pair_port[s][w])) return;
         pair_port[s][w] = p;
         pair_dist[s][w] = d;
      end
      // trim down to the limit
      while (pair_total(s) > effective_limit()) pair_used[s][worst_pair(s)] = 1'b0;
   endfunction

   // work out the response of one command and update the table
   function automatic nhrt_rsp_type predict_route_rsp(nhrt_req_type r);
      nhrt_rsp_type o;
      int s, k, b, start;
      o = '0;
      case (r.command)
         CMD_UPDATE: begin
            s = slot_of(r.dest_address);
            if (s >= 0) add_pair(s, r.port_number, r.distance_in);
            else begin
               k = -1;
               for (int i = SLOTS - 1; i >= 0; i--) if (!slot_used[i]) k = i;
               if (k < 0) o.status = STS_FULL;
               else begin
                  free_slot(k);
                  slot_used[k] = 1'b1;
                  slot_addr[k] = r.dest_address;
                  add_pair(k, r.port_number, r.distance_in);
                  cursor = k;
               end
            end
         end
         CMD_DETACH: begin
            for (int i = 0; i < SLOTS; i++) if (slot_used[i]) begin
               for (int h = 0; h < HOPS; h++)
                  if (pair_used[i][h] && pair_port[i][h] == r.port_number)
                     pair_used[i][h] = 1'b0;
               if (pair_total(i) == 0) free_slot(i);
            end
         end
         CMD_REMOVE: begin
            s = slot_of(r.dest_address);
            if (s >= 0) free_slot(s); else o.status = STS_NOTFOUND;
         end
         CMD_QUERY: begin
            s = slot_of(r.dest_address);
            b = (s >= 0) ? best_pair(s) : -1;
            if (b >= 0) begin
               o.found = 1'b1;
               o.next_port = pair_port[s][b];
            end else o.status = STS_NOTFOUND;
         end
         CMD_NEXT: begin
            start = (cursor >= SLOTS) ? 0 : cursor;
            s = -1;
            for (int i = 0; i < SLOTS && s < 0; i++)
               if (slot_used[(start + i) % SLOTS]) s = (start + i) % SLOTS;
            if (s < 0) o.status = STS_NOTFOUND;
            else begin
               b = best_pair(s);
               o.found = 1'b1;
               o.route_address = slot_addr[s];
               o.route_distance = (b >= 0) ? pair_dist[s][b] : '0;
               cursor = s + 1;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // send one item; valid stays up only when the next item follows at once
   task automatic send_item(nhrt_req_type r);
      repeat (next_gap) @(posedge clock);
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      expected_rsps.push_back(predict_route_rsp(r));
      next_gap = $urandom_range(0, 6);
      req_hold = (next_gap == 0);
      if (!req_hold) req_valid <= 1'b0;
   endtask

   // drop valid when no item follows right away
   task automatic req_idle();
      if (req_hold) begin
         req_valid <= 1'b0;
         req_hold = 1'b0;
         next_gap = 1;
      end
   endtask

   task automatic send_cmd(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
                           logic [PORT_W-1:0] p, logic [DIST_W-1:0] d);
      nhrt_req_type r;
      r.command = c;
      r.dest_address = a;
      r.port_number = p;
      r.distance_in = d;
      send_item(r);
   endtask

   // wait for the block to go idle, then write the hop limit
   task automatic write_hop_limit(logic [LIM_REG_W-1:0] v);
      req_idle();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (ITEM_CYCLES + 4) @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= LIMIT_REG_ADDR;
      pwdata <= 32'(v);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      hop_limit_reg = v;
   endtask

   // response checker with random stalls
   initial begin
      nhrt_rsp_type e;
      int gap;
      forever begin
         gap = $urandom_range(0, 6);
         if ($urandom_range(0, 3) == 0) gap = 0;
         while (gap > 0 || hold_off) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
            if (gap > 0) gap--;
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %p", $time, rsp_payload);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_payload.status !== e.status) begin
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_payload.status);
               errors++;
            end
            if (rsp_payload.found !== e.found) begin
               $display("%0t: found exp %0d got %0d", $time, e.found, rsp_payload.found);
               errors++;
            end
            if (rsp_payload.route_address !== e.route_address) begin
               $display("%0t: route_address exp %h got %h", $time, e.route_address,
                        rsp_payload.route_address);
               errors++;
            end
            if (rsp_payload.next_port !== e.next_port) begin
               $display("%0t: next_port exp %0d got %0d", $time, e.next_port,
                        rsp_payload.next_port);
               errors++;
            end
            if (rsp_payload.route_distance !== e.route_distance) begin
               $display("%0t: route_distance exp %0d got %0d", $time, e.route_distance,
                        rsp_payload.route_distance);
               errors++;
            end
         end
      end
   end

   // receiver held off for a long stretch while items keep coming
   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (4 * ITEM_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (int i = 0; i < 6; i++)
               send_cmd(CMD_UPDATE, 16'h0100 + 16'(i), 4'(i), 8'(i));
            req_idle();
         end
      join
   endtask

   task automatic test_directed();
      // empty table cases
      send_cmd(CMD_NEXT, 16'h0, 4'h0, 8'h0);
      send_cmd(CMD_QUERY, 16'hffff, 4'h0, 8'h0);
      send_cmd(CMD_REMOVE, 16'h0, 4'h0, 8'h0);
      // extremes, ties and overflow of the pairs
      send_cmd(CMD_UPDATE, 16'hffff, 4'hf, 8'hff);
      send_cmd(CMD_UPDATE, 16'hffff, 4'h3, 8'hff);
      send_cmd(CMD_UPDATE, 16'hffff, 4'h3, 8'hff);
      send_cmd(CMD_UPDATE, 16'hffff, 4'h1, 8'h10);
      send_cmd(CMD_UPDATE, 16'hffff, 4'h2, 8'h10);
      send_cmd(CMD_UPDATE, 16'hffff, 4'h0, 8'h00);
      send_cmd(CMD_UPDATE, 16'hffff, 4'h9, 8'hff);
      send_cmd(CMD_QUERY, 16'hffff, 4'h0, 8'h0);
      send_cmd(CMD_UPDATE, 16'h0000, 4'h5, 8'h00);
      send_cmd(CMD_NEXT, 16'h0, 4'h0, 8'h0);
      send_cmd(CMD_NEXT, 16'h0, 4'h0, 8'h0);
      send_cmd(CMD_DETACH, 16'h0, 4'h5, 8'h0);
      send_cmd(CMD_QUERY, 16'h0000, 4'h0, 8'h0);
      send_cmd(CMD_BAD_LO, 16'hffff, 4'hf, 8'hff);
      send_cmd(CMD_BAD_HI, 16'h1234, 4'h1, 8'h1);
      send_cmd(CMD_REMOVE, 16'hffff, 4'h0, 8'h0);
      send_cmd(CMD_NEXT, 16'h0, 4'h0, 8'h0);
   endtask

   // fill every slot, then hit the full table
   task automatic test_table_full();
      for (int i = 0; i <= SLOTS; i++)
         send_cmd(CMD_UPDATE, 16'h8000 + 16'(i), 4'($urandom_range(0, 15)), 8'($urandom));
      send_cmd(CMD_NEXT, 16'h0, 4'h0, 8'h0);
      for (int p = 0; p < 16; p++) send_cmd(CMD_DETACH, 16'h0, 4'(p), 8'h0);
   endtask

   // random commands over a small address pool so entries get reused
   task automatic test_random(int n);
      nhrt_req_type r;
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         r = '0;
         r.dest_address = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                          : addr_pool[$urandom_range(0, 7)];
         r.port_number = 4'($urandom);
         r.distance_in = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 7)) : 8'($urandom);
         if (sel < 50) r.command = CMD_UPDATE;
         else if (sel < 54) r.command = CMD_DETACH;
         else if (sel < 62) r.command = CMD_REMOVE;
         else if (sel < 80) r.command = CMD_QUERY;
         else if (sel < 97) r.command = CMD_NEXT;
         else r.command = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
         send_item(r);
      end
   endtask

   initial begin
      hop_limit_reg = LIM_RESET;
      cursor = SLOTS;
      for (int s = 0; s < SLOTS; s++) begin
         slot_used[s] = 1'b0;
         slot_addr[s] = '0;
         for (int h = 0; h < HOPS; h++) begin
            pair_used[s][h] = 1'b0;
            pair_port[s][h] = '0;
            pair_dist[s][h] = '0;
         end
      end
      for (int i = 0; i < 8; i++) addr_pool[i] = 16'($urandom);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_backpressure();
      test_table_full();
      write_hop_limit(3'd1);
      test_random(300);
      write_hop_limit(3'd0);
      test_random(200);
      write_hop_limit(3'd7);
      test_random(300);
      write_hop_limit(3'd2);
      test_random(300);
      write_hop_limit(3'd4);
      test_random(300);

      req_idle();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (ITEM_CYCLES + 10) @(posedge clock);
      $display("covered directed edge cases, a full table, a long output stall and");
      $display("random traffic under hop limits 0 to 7; %0d responses checked", rsp_count);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
